/* rtl/cron_schedule_matcher_macros.svh */
`ifndef CRON_SCHEDULE_MATCHER_MACROS_SVH
`define CRON_SCHEDULE_MATCHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRONM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cron matcher check failed");

// next-cycle implication, checked outside reset
`define CRONM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cron matcher check failed");

`endif

/* rtl/cronm_pkg.sv */
package cronm_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int MIN_BITS  = 60;
  localparam int HOUR_BITS = 24;
  localparam int DAY_BITS  = 32;
  localparam int MON_BITS  = 12;
  localparam int DOW_BITS  = 7;

  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 5;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic take;     // request accepted this cycle
    logic step;     // evaluate current entry and advance
    logic finish;   // load closing result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic hit;
    logic pend_valid;
    logic out_busy;
    logic scan_end;
  } status_t;

endpackage

/* rtl/cron_schedule_matcher_if.sv */
interface cronm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [59:0] minute_mask;
  logic [23:0] hour_mask;
  logic [31:0] day_mask;
  logic [11:0] month_mask;
  logic [6:0]  weekday_mask;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day_of_month;
  logic [3:0]  month;
  logic [2:0]  weekday;

  modport source (
    output valid, kind, slot, minute_mask, hour_mask, day_mask, month_mask,
           weekday_mask, minute, hour, day_of_month, month, weekday,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, minute_mask, hour_mask, day_mask, month_mask,
           weekday_mask, minute, hour, day_of_month, month, weekday,
    output ready
  );
endinterface

interface cronm_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] matched_slot;
  logic       matched;
  logic       last;
  logic [4:0] match_total;

  modport source (
    output valid, matched_slot, matched, last, match_total,
    input  ready
  );
  modport sink (
    input  valid, matched_slot, matched, last, match_total,
    output ready
  );
endinterface

/* rtl/cronm_ctrl.sv */
module cronm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cronm_pkg::status_t st,
  output cronm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  // a second hit cannot push out the held one while the result register is full
  assign stall = st.hit && st.pend_valid && st.out_busy;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take = 1'b1;
          if (st.is_tick) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.step = 1'b1;
          if (st.scan_end) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/cronm_dp.sv */
module cronm_dp #(
  parameter int ENTRIES = cronm_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cronm_pkg::cmd_t                   cmd,
  output cronm_pkg::status_t                st,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic [1:0]                        kind,
  input  logic [cronm_pkg::SLOT_W-1:0]      slot,
  input  logic [cronm_pkg::MIN_BITS-1:0]    minute_mask,
  input  logic [cronm_pkg::HOUR_BITS-1:0]   hour_mask,
  input  logic [cronm_pkg::DAY_BITS-1:0]    day_mask,
  input  logic [cronm_pkg::MON_BITS-1:0]    month_mask,
  input  logic [cronm_pkg::DOW_BITS-1:0]    weekday_mask,
  input  logic [5:0]                        minute,
  input  logic [4:0]                        hour,
  input  logic [4:0]                        day_of_month,
  input  logic [3:0]                        month,
  input  logic [2:0]                        weekday,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cronm_pkg::SLOT_W-1:0]      matched_slot,
  output logic                              matched,
  output logic                              last,
  output logic [cronm_pkg::TOTAL_W-1:0]     match_total
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WIDE_W = cronm_pkg::SLOT_W + IDX_W;

  // entry storage, no reset on the masks
  logic [cronm_pkg::MIN_BITS-1:0]  min_mem [ENTRIES];
  logic [cronm_pkg::HOUR_BITS-1:0] hour_mem [ENTRIES];
  logic [cronm_pkg::DAY_BITS-1:0]  day_mem [ENTRIES];
  logic [cronm_pkg::MON_BITS-1:0]  mon_mem [ENTRIES];
  logic [cronm_pkg::DOW_BITS-1:0]  dow_mem [ENTRIES];
  logic [ENTRIES-1:0]              entry_valid;

  logic service_enabled;

  // latched tick time
  logic [5:0] t_min;
  logic [4:0] t_hour;
  logic [4:0] t_day;
  logic [3:0] t_mon;
  logic [2:0] t_dow;

  // scan state
  logic [IDX_W-1:0]                  scan_idx;
  logic [cronm_pkg::TOTAL_W-1:0]     count;
  logic                              pend_valid;
  logic [cronm_pkg::SLOT_W-1:0]      pend_slot;

  logic [WIDE_W-1:0] slot_wide;
  logic              slot_ok;
  logic [IDX_W-1:0]  wr_idx;
  logic              day_r;
  logic              dow_r;
  logic [cronm_pkg::DAY_BITS-1:0] day_fixed;
  logic [cronm_pkg::DOW_BITS-1:0] dow_fixed;
  logic              min_hit;
  logic              hour_hit;
  logic              mon_hit;
  logic              day_hit;
  logic              dow_hit;
  logic              load;
  logic [cronm_pkg::SLOT_W-1:0]  load_slot;
  logic                          load_matched;
  logic                          load_last;
  logic [cronm_pkg::TOTAL_W-1:0] load_total;

  assign slot_wide = WIDE_W'(slot);
  assign slot_ok   = slot_wide < WIDE_W'(ENTRIES);
  assign wr_idx    = slot_wide[IDX_W-1:0];

  // day/weekday fix: a restricted field wins over an unrestricted one
  assign day_r = (day_mask != '0) && (day_mask != '1);
  assign dow_r = (weekday_mask != '0) && (weekday_mask != '1);
  assign day_fixed = (dow_r && !day_r) ? '0 : day_mask;
  assign dow_fixed = (day_r && !dow_r) ? '0 : weekday_mask;

  // out-of-range time bits never match
  assign min_hit  = (t_min < 6'(cronm_pkg::MIN_BITS)) && min_mem[scan_idx][t_min];
  assign hour_hit = (t_hour < 5'(cronm_pkg::HOUR_BITS)) && hour_mem[scan_idx][t_hour];
  assign mon_hit  = (t_mon < 4'(cronm_pkg::MON_BITS)) && mon_mem[scan_idx][t_mon];
  assign day_hit  = day_mem[scan_idx][t_day];
  assign dow_hit  = (t_dow < 3'(cronm_pkg::DOW_BITS)) && dow_mem[scan_idx][t_dow];

  assign st.is_tick    = kind == cronm_pkg::KIND_TICK;
  assign st.hit        = service_enabled && entry_valid[scan_idx] && min_hit && hour_hit &&
                         mon_hit && (day_hit || dow_hit);
  assign st.pend_valid = pend_valid;
  assign st.out_busy   = out_valid && !out_ready;
  assign st.scan_end   = scan_idx == IDX_W'(ENTRIES - 1);

  // result load: held hit out on a newer hit or as the close; else an empty close
  always_comb begin
    load         = 1'b0;
    load_slot    = pend_slot;
    load_matched = 1'b1;
    load_last    = 1'b0;
    load_total   = '0;
    if (cmd.step && st.hit && pend_valid) begin
      load = 1'b1;
    end else if (cmd.finish) begin
      load = 1'b1;
      load_last = 1'b1;
      if (pend_valid) begin
        load_total = count;
      end else begin
        load_slot    = '0;
        load_matched = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && slot_ok && kind == cronm_pkg::KIND_WRITE) begin
      min_mem[wr_idx]  <= minute_mask;
      hour_mem[wr_idx] <= hour_mask;
      day_mem[wr_idx]  <= day_fixed;
      mon_mem[wr_idx]  <= month_mask;
      dow_mem[wr_idx]  <= dow_fixed;
    end
    if (cmd.take && st.is_tick) begin
      t_min  <= minute;
      t_hour <= hour;
      t_day  <= day_of_month;
      t_mon  <= month;
      t_dow  <= weekday;
    end
    if (cmd.step && st.hit) begin
      pend_slot <= cronm_pkg::SLOT_W'(scan_idx);
    end
    if (load) begin
      matched_slot <= load_slot;
      matched      <= load_matched;
      last         <= load_last;
      match_total  <= load_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid     <= '0;
      service_enabled <= 1'b0;
      scan_idx        <= '0;
      count           <= '0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        service_enabled <= cfg_wdata;
      end
      if (cmd.take && slot_ok) begin
        if (kind == cronm_pkg::KIND_WRITE) begin
          entry_valid[wr_idx] <= 1'b1;
        end else if (kind == cronm_pkg::KIND_CLEAR) begin
          entry_valid[wr_idx] <= 1'b0;
        end
      end
      if (cmd.take && st.is_tick) begin
        scan_idx   <= '0;
        count      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.step) begin
        scan_idx <= scan_idx + 1'b1;
        if (st.hit) begin
          pend_valid <= 1'b1;
          count      <= count + 1'b1;
        end
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/cron_schedule_matcher.sv */
// channel  | dir | contents
// ---------+-----+--------------------------------------------------------
// req      | in  | write entry, clear slot or minute tick with its fields
// rsp      | out | matched slot, matched, last, match_total per result
// cfg      | in  | cfg_we / cfg_wdata set service_enabled
//
// write and clear leave the controller idle; the next request is taken the cycle after
// a tick goes through accept, one scan step per table entry, then close
// the entry scan runs one slot per cycle over the register table while not stalled
// rst is synchronous and clears the valid bits, the controller and the output valid
// a full result register stalls the scan only when a new hit must push out the held one

`include "cron_schedule_matcher_macros.svh"

module cron_schedule_matcher #(
  parameter int ENTRIES = cronm_pkg::ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cronm_req_if.sink    req,
  cronm_rsp_if.source  rsp,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  cronm_pkg::cmd_t    cmd;
  cronm_pkg::status_t st;

  // sequencer: idle, scan, close
  cronm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // entry table, tick time, held hit and result register
  cronm_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .kind         (req.kind),
    .slot         (req.slot),
    .minute_mask  (req.minute_mask),
    .hour_mask    (req.hour_mask),
    .day_mask     (req.day_mask),
    .month_mask   (req.month_mask),
    .weekday_mask (req.weekday_mask),
    .minute       (req.minute),
    .hour         (req.hour),
    .day_of_month (req.day_of_month),
    .month        (req.month),
    .weekday      (req.weekday),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .matched_slot (rsp.matched_slot),
    .matched      (rsp.matched),
    .last         (rsp.last),
    .match_total  (rsp.match_total)
  );

  // the total rides only on the closing result
  `CRONM_ASSERT_NOW(a_total_on_last, clk, rst, rsp.valid && rsp.match_total != 5'd0, rsp.last)
  // an empty result is the single closing one and names slot zero
  `CRONM_ASSERT_NOW(a_empty_result, clk, rst, rsp.valid && !rsp.matched,
                    rsp.last && rsp.matched_slot == 4'd0 && rsp.match_total == 5'd0)
  // a closing hit reports at least one match
  `CRONM_ASSERT_NOW(a_hit_total, clk, rst, rsp.valid && rsp.last && rsp.matched,
                    rsp.match_total != 5'd0)
  // a tick holds off further requests while the table is scanned
  `CRONM_ASSERT_NEXT(a_tick_busy, clk, rst,
                     req.valid && req.ready && req.kind == cronm_pkg::KIND_TICK, !req.ready)

endmodule
